[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BES_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("barcode_error_stats assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("barcode_error_stats assertion failed");

`endif

[rtl/bes_pkg.sv]
// ---------------------------------------------------------------------------
// Barcode error statistics package
// Command codes, counter selects, memory operation type and helpers.
// ---------------------------------------------------------------------------
package bes_pkg;

    localparam logic [2:0] CMD_BASE   = 3'd0;
    localparam logic [2:0] CMD_UNREC  = 3'd1;
    localparam logic [2:0] CMD_RUN_RD = 3'd2;
    localparam logic [2:0] CMD_ERR_RD = 3'd3;
    localparam logic [2:0] CMD_CNT_RD = 3'd4;

    localparam logic [9:0] SEL_ERROR_FREE = 10'd0;
    localparam logic [9:0] SEL_ONE_ERROR  = 10'd1;
    localparam logic [9:0] SEL_UNREC      = 10'd2;

    typedef struct packed {
        logic inc;
        logic query;
    } bes_mem_op_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

endpackage

[rtl/bes_hist_ram.sv]
// ---------------------------------------------------------------------------
// Histogram RAM
// Saturating read-modify-write histogram with write-back forwarding and a
// clearing sweep after reset.
// ---------------------------------------------------------------------------
module bes_hist_ram
    import bes_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  bes_mem_op_t   op,
    input  logic [AW-1:0] addr,
    output logic          busy,
    output logic [31:0]   rd_data
);

    logic [31:0]   mem [DEPTH];
    logic [31:0]   rdata_reg;
    logic          s1_inc_reg;
    logic [AW-1:0] s1_addr_reg;
    logic          byp_vld_reg;
    logic [AW-1:0] byp_addr_reg;
    logic [31:0]   byp_data_reg;
    logic          clr_act_reg;
    logic [AW-1:0] clr_addr_reg;
    logic [31:0]   inc_data;

    assign rd_data  = (byp_vld_reg && byp_addr_reg == s1_addr_reg) ? byp_data_reg : rdata_reg;
    assign inc_data = sat_inc(rd_data);
    assign busy     = clr_act_reg;

    always_ff @(posedge clk)
    begin
        if (clr_act_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (s1_inc_reg)
        begin
            mem[s1_addr_reg] <= inc_data;
        end
        if (op.inc || op.query)
        begin
            rdata_reg <= mem[addr];
        end
        s1_addr_reg  <= addr;
        byp_addr_reg <= s1_addr_reg;
        byp_data_reg <= inc_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_inc_reg   <= 1'b0;
            byp_vld_reg  <= 1'b0;
            clr_act_reg  <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            s1_inc_reg  <= op.inc;
            byp_vld_reg <= s1_inc_reg;
            if (clr_act_reg)
            begin
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    clr_act_reg <= 1'b0;
                end
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

endmodule

[rtl/barcode_error_stats.sv]
// ---------------------------------------------------------------------------
// Barcode error statistics
// Counts error-free, one-mismatch and unrecognised reads, builds a quality/position
// histogram of single mismatches and a histogram of barcode run lengths.
// ---------------------------------------------------------------------------
// Throughput: one item per cycle unless tready is low (RAM sweep, full result FIFO);
// per-read state updates in the accept cycle. A query result passes through the s1
// registers and the output FIFO before it is offered on m_axis. Histogram bumps
// are read-modify-write on RAMs with a registered read, with the previous write
// forwarded to a following read of the same entry. Reset clears all counters,
// then both RAMs are swept clear with tready low.
module barcode_error_stats
    import bes_pkg::*;
#(
    parameter int MAX_LEN     = 16,
    parameter int HIST_BINS   = 1000,
    parameter int QUAL_LEVELS = 128
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // raw_base[2:0], corrected_base[4:3], quality[11:5], query_position[15:12],
    // query_index[25:16], zero padding[31:26]
    input  logic [31:0] s_axis_tdata,
    // cmd[2:0]
    input  logic [2:0]  s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[31:0]
    output logic [31:0] m_axis_tdata
);

    localparam int BW     = 2 * MAX_LEN;
    localparam int LW     = $clog2(MAX_LEN + 1);
    localparam int PW     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int QW     = $clog2(QUAL_LEVELS);
    localparam int RAW    = $clog2(HIST_BINS);
    localparam int EDEPTH = QUAL_LEVELS * (2 ** PW);
    localparam int EAW    = QW + PW;

    typedef enum logic [1:0] {SRC_REG, SRC_RUN, SRC_ERR} src_t;

    logic [2:0] cmd;
    logic [2:0] raw_base;
    logic [1:0] corrected_base;
    logic [6:0] quality;
    logic       last;
    logic [3:0] query_position;
    logic [9:0] query_index;

    assign cmd            = s_axis_tuser;
    assign raw_base       = s_axis_tdata[2:0];
    assign corrected_base = s_axis_tdata[4:3];
    assign quality        = s_axis_tdata[11:5];
    assign query_position = s_axis_tdata[15:12];
    assign query_index    = s_axis_tdata[25:16];
    assign last           = s_axis_tlast;

    logic [BW-1:0] cur_bc_reg, cur_bc_next, prev_bc_reg, prev_bc_next;
    logic [LW-1:0] cur_pos_reg, cur_pos_next, prev_len_reg, prev_len_next;
    logic [31:0]   run_len_reg, run_len_next;
    logic [1:0]    mm_cnt_reg, mm_cnt_next;
    logic [PW-1:0] mm_pos_reg, mm_pos_next;
    logic [6:0]    mm_qual_reg, mm_qual_next;
    logic [31:0]   ef_cnt_reg, ef_cnt_next;
    logic [31:0]   oe_cnt_reg, oe_cnt_next;
    logic [31:0]   un_cnt_reg, un_cnt_next;

    logic          s1_res_reg, s1_res_next;
    src_t          s1_src_reg, s1_src_next;
    logic [31:0]   s1_val_reg, s1_val_next;

    logic [31:0]   fifo_mem [3];
    logic [1:0]    wr_ptr_reg, rd_ptr_reg, cnt_reg;

    logic          acc, push, pop, busy_run, busy_err;
    bes_mem_op_t   run_op, err_op;
    logic [RAW-1:0] run_addr;
    logic [EAW-1:0] err_addr;
    logic [31:0]   run_rd_data, err_rd_data, res_data;

    logic [BW-1:0] bc_w;
    logic [LW-1:0] pos_w;
    logic [1:0]    mc_w;
    logic [PW-1:0] mp_w;
    logic [6:0]    mq_w;
    logic [31:0]   qidx_w, qual_w, qpos_w, mq32_w;
    logic [QW-1:0] row_w;

    assign acc           = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !busy_run && !busy_err && (({1'b0, cnt_reg} + 3'(s1_res_reg)) < 3'd3);
    assign qidx_w        = 32'(query_index);
    assign qual_w        = 32'(quality);
    assign qpos_w        = 32'(query_position);

    always_comb
    begin
        cur_bc_next   = cur_bc_reg;
        cur_pos_next  = cur_pos_reg;
        prev_bc_next  = prev_bc_reg;
        prev_len_next = prev_len_reg;
        run_len_next  = run_len_reg;
        mm_cnt_next   = mm_cnt_reg;
        mm_pos_next   = mm_pos_reg;
        mm_qual_next  = mm_qual_reg;
        ef_cnt_next   = ef_cnt_reg;
        oe_cnt_next   = oe_cnt_reg;
        un_cnt_next   = un_cnt_reg;
        s1_res_next   = 1'b0;
        s1_src_next   = SRC_REG;
        s1_val_next   = '0;
        run_op        = '0;
        err_op        = '0;
        run_addr      = qidx_w[RAW-1:0];
        err_addr      = {qual_w[QW-1:0], qpos_w[PW-1:0]};
        bc_w          = cur_bc_reg;
        pos_w         = cur_pos_reg;
        mc_w          = mm_cnt_reg;
        mp_w          = mm_pos_reg;
        mq_w          = mm_qual_reg;
        mq32_w        = '0;
        row_w         = '0;
        if (acc)
        begin
            unique case (cmd)
                CMD_BASE:
                begin
                    if (32'(cur_pos_reg) < 32'(MAX_LEN))
                    begin
                        for (int i = 0; i < MAX_LEN; i++)
                        begin
                            if (cur_pos_reg == LW'(i))
                            begin
                                bc_w[2*i +: 2] = corrected_base;
                            end
                        end
                        if (raw_base != {1'b0, corrected_base})
                        begin
                            if (mm_cnt_reg == 2'd0)
                            begin
                                mp_w = cur_pos_reg[PW-1:0];
                                mq_w = quality;
                            end
                            if (mm_cnt_reg < 2'd2)
                            begin
                                mc_w = mm_cnt_reg + 2'd1;
                            end
                        end
                        pos_w = cur_pos_reg + 1'b1;
                    end
                    cur_bc_next  = bc_w;
                    cur_pos_next = pos_w;
                    mm_cnt_next  = mc_w;
                    mm_pos_next  = mp_w;
                    mm_qual_next = mq_w;
                    if (last)
                    begin
                        if (bc_w == prev_bc_reg && pos_w == prev_len_reg)
                        begin
                            run_len_next = sat_inc(run_len_reg);
                        end
                        else
                        begin
                            if (run_len_reg != '0)
                            begin
                                run_op.inc = 1'b1;
                                run_addr   = (run_len_reg < 32'(HIST_BINS - 1))
                                             ? run_len_reg[RAW-1:0] : RAW'(HIST_BINS - 1);
                            end
                            prev_bc_next  = bc_w;
                            prev_len_next = pos_w;
                            run_len_next  = 32'd1;
                        end
                        if (mc_w == 2'd0)
                        begin
                            ef_cnt_next = sat_inc(ef_cnt_reg);
                        end
                        else if (mc_w == 2'd1)
                        begin
                            mq32_w     = 32'(mq_w);
                            row_w      = (mq32_w < 32'(QUAL_LEVELS))
                                         ? mq32_w[QW-1:0] : QW'(QUAL_LEVELS - 1);
                            err_op.inc = 1'b1;
                            err_addr   = {row_w, mp_w};
                            oe_cnt_next = sat_inc(oe_cnt_reg);
                        end
                        cur_bc_next  = '0;
                        cur_pos_next = '0;
                        mm_cnt_next  = '0;
                        mm_pos_next  = '0;
                        mm_qual_next = '0;
                    end
                end
                CMD_UNREC:
                begin
                    un_cnt_next  = sat_inc(un_cnt_reg);
                    cur_bc_next  = '0;
                    cur_pos_next = '0;
                    mm_cnt_next  = '0;
                    mm_pos_next  = '0;
                    mm_qual_next = '0;
                end
                CMD_RUN_RD:
                begin
                    s1_res_next = 1'b1;
                    if (qidx_w < 32'(HIST_BINS))
                    begin
                        run_op.query = 1'b1;
                        s1_src_next  = SRC_RUN;
                    end
                end
                CMD_ERR_RD:
                begin
                    s1_res_next = 1'b1;
                    if (qual_w < 32'(QUAL_LEVELS) && qpos_w < 32'(MAX_LEN))
                    begin
                        err_op.query = 1'b1;
                        s1_src_next  = SRC_ERR;
                    end
                end
                CMD_CNT_RD:
                begin
                    s1_res_next = 1'b1;
                    case (query_index)
                        SEL_ERROR_FREE: s1_val_next = ef_cnt_reg;
                        SEL_ONE_ERROR:  s1_val_next = oe_cnt_reg;
                        SEL_UNREC:      s1_val_next = un_cnt_reg;
                        default:        s1_val_next = '0;
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    bes_hist_ram #(
        .DEPTH (HIST_BINS),
        .AW    (RAW)
    ) u_run_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (run_op),
        .addr    (run_addr),
        .busy    (busy_run),
        .rd_data (run_rd_data)
    );

    bes_hist_ram #(
        .DEPTH (EDEPTH),
        .AW    (EAW)
    ) u_err_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (err_op),
        .addr    (err_addr),
        .busy    (busy_err),
        .rd_data (err_rd_data)
    );

    always_comb
    begin
        case (s1_src_reg)
            SRC_RUN: res_data = run_rd_data;
            SRC_ERR: res_data = err_rd_data;
            default: res_data = s1_val_reg;
        endcase
    end

    assign push          = s1_res_reg;
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = fifo_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= res_data;
        end
        s1_val_reg <= s1_val_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_bc_reg   <= '0;
            cur_pos_reg  <= '0;
            prev_bc_reg  <= '0;
            prev_len_reg <= '0;
            run_len_reg  <= '0;
            mm_cnt_reg   <= '0;
            mm_pos_reg   <= '0;
            mm_qual_reg  <= '0;
            ef_cnt_reg   <= '0;
            oe_cnt_reg   <= '0;
            un_cnt_reg   <= '0;
            s1_res_reg   <= 1'b0;
            s1_src_reg   <= SRC_REG;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            cur_bc_reg   <= cur_bc_next;
            cur_pos_reg  <= cur_pos_next;
            prev_bc_reg  <= prev_bc_next;
            prev_len_reg <= prev_len_next;
            run_len_reg  <= run_len_next;
            mm_cnt_reg   <= mm_cnt_next;
            mm_pos_reg   <= mm_pos_next;
            mm_qual_reg  <= mm_qual_next;
            ef_cnt_reg   <= ef_cnt_next;
            oe_cnt_reg   <= oe_cnt_next;
            un_cnt_reg   <= un_cnt_next;
            s1_res_reg   <= s1_res_next;
            s1_src_reg   <= s1_src_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == 2'd2) ? 2'd0 : wr_ptr_reg + 2'd1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == 2'd2) ? 2'd0 : rd_ptr_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

[rtl/bes_checker.sv]
// ---------------------------------------------------------------------------
// Barcode error statistics checker
// Port-level assertions on the statistics block, attached by bind.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bes_checker
    import bes_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    logic q_acc;

    assign q_acc = s_axis_tvalid && s_axis_tready
                   && (s_axis_tuser == CMD_RUN_RD || s_axis_tuser == CMD_ERR_RD
                       || s_axis_tuser == CMD_CNT_RD);

    `BES_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `BES_ASSERT_NEXT(a_out_stable, clk, rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    `BES_ASSERT_NOW(a_result_follows_query, clk, rst_n, $rose(m_axis_tvalid), $past(q_acc, 2))
    `BES_ASSERT_NEXT(a_no_spurious_result, clk, rst_n, !m_axis_tvalid && !$past(q_acc), !m_axis_tvalid)

endmodule

bind barcode_error_stats bes_checker u_bes_checker (.*);
